/* src/gnc_pkg.sv */
// shared types and constants of the grid neighbor cell finder
package gnc_pkg;

  localparam int POS_W     = 32;  // q16.16 coordinate
  localparam int REL_W     = 33;  // position minus origin
  localparam int OFF_W     = 35;  // relative position plus half-cell shift
  localparam int LEN_W     = 31;  // cell length and reciprocal
  localparam int HALF_W    = 30;  // half cell length
  localparam int CNT_REG_W = 7;   // cells per axis register
  localparam int SLOT_W    = 4;
  localparam int IDX_OUT_W = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int PROD_W    = 64;  // full offset times reciprocal product
  localparam int Q_W       = 32;  // integer part of the product
  localparam int MUL_LO_W  = 16;  // low partial product operand
  localparam int MUL_HI_W  = 17;  // high partial product operand
  localparam int NUM_AXES  = 3;
  localparam int NUM_CLS   = 3;
  localparam int NUM_SLOTS = 9;
  localparam int FIFO_DEPTH = 4;

  localparam logic [SLOT_W-1:0] FIRST_SLOT = 4'd0;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = 4'd8;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_CELL_LEN   = 3'd3,
    REG_INV_LEN    = 3'd4,
    REG_CELLS_X    = 3'd5,
    REG_CELLS_Y    = 3'd6,
    REG_CELLS_Z    = 3'd7
  } reg_idx_t;

  // shift class of one axis: minus half cell, unshifted, plus half cell
  typedef enum logic [1:0] {
    CLS_MINUS  = 2'd0,
    CLS_CENTER = 2'd1,
    CLS_PLUS   = 2'd2
  } cls_t;

  // per axis and shift class: coordinate lies inside the grid
  typedef struct packed {
    logic [NUM_CLS-1:0] in_z;
    logic [NUM_CLS-1:0] in_y;
    logic [NUM_CLS-1:0] in_x;
  } grid_flags_t;

endpackage

/* src/gnc_front.sv */
// front end: accepts positions and computes the nine axis indices per position
module gnc_front #(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    in_valid,
  output logic                                                    in_stall,
  input  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::POS_W-1:0]        pos,
  input  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::POS_W-1:0]        origin,
  input  logic [gnc_pkg::HALF_W-1:0]                              half_len,
  input  logic [gnc_pkg::LEN_W-1:0]                               inv_len,
  input  logic [gnc_pkg::NUM_AXES-1:0][CW-1:0]                    eff_cnt,
  input  logic                                                    pop,
  output logic                                                    push,
  output logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0][IW-1:0] push_idx,
  output gnc_pkg::grid_flags_t                                    push_flags
);

  localparam int OCC_W = $clog2(gnc_pkg::FIFO_DEPTH + 1);
  localparam int PL_W  = gnc_pkg::MUL_LO_W + gnc_pkg::LEN_W;
  localparam int PH_W  = gnc_pkg::MUL_HI_W + gnc_pkg::LEN_W;

  logic                        busy_r, busy_nxt;
  gnc_pkg::cls_t               ph_r, ph_nxt;
  logic [OCC_W-1:0]            occ_r, occ_nxt;
  logic                        accept;

  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::REL_W-1:0] rel_r;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::OFF_W-1:0] off_a;

  logic                        b_vld_r;
  gnc_pkg::cls_t               b_cls_r;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::OFF_W-1:0] b_off_r;
  logic [gnc_pkg::NUM_AXES-1:0][PL_W-1:0]           pl_b;
  logic [gnc_pkg::NUM_AXES-1:0][PH_W-1:0]           ph_b;

  logic                        c_vld_r;
  gnc_pkg::cls_t               c_cls_r;
  logic [gnc_pkg::NUM_AXES-1:0]                     c_neg_r;
  logic [gnc_pkg::NUM_AXES-1:0][PL_W-1:0]           c_pl_r;
  logic [gnc_pkg::NUM_AXES-1:0][PH_W-1:0]           c_ph_r;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::PROD_W-1:0] sum_c;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::Q_W-1:0]   q_c;
  logic [gnc_pkg::NUM_AXES-1:0]                     in_c;

  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0][IW-1:0] asm_idx_r;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0]         asm_in_r;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0]         push_in;

  // accepts only when idle or in the plus class, and while the queue has room
  assign in_stall = (busy_r && (ph_r != gnc_pkg::CLS_PLUS)) ||
                    (occ_r == OCC_W'(gnc_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    if (busy_r) begin
      ph_nxt = (ph_r == gnc_pkg::CLS_MINUS) ? gnc_pkg::CLS_CENTER : gnc_pkg::CLS_PLUS;
      if (ph_r == gnc_pkg::CLS_PLUS) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      ph_nxt   = gnc_pkg::CLS_MINUS;
    end
    occ_nxt = occ_r + OCC_W'(accept) - OCC_W'(pop);
  end

  // stage a: apply the half-cell shift of the current class
  always_comb begin
    for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
      off_a[a] = {{(gnc_pkg::OFF_W - gnc_pkg::REL_W){rel_r[a][gnc_pkg::REL_W-1]}}, rel_r[a]};
      if (ph_r == gnc_pkg::CLS_MINUS) begin
        off_a[a] = off_a[a] - gnc_pkg::OFF_W'(half_len);
      end else if (ph_r == gnc_pkg::CLS_PLUS) begin
        off_a[a] = off_a[a] + gnc_pkg::OFF_W'(half_len);
      end
    end
  end

  // stage b: two partial products per axis
  always_comb begin
    for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
      pl_b[a] = PL_W'(b_off_r[a][gnc_pkg::MUL_LO_W-1:0]) * PL_W'(inv_len);
      ph_b[a] = PH_W'(b_off_r[a][gnc_pkg::MUL_LO_W+gnc_pkg::MUL_HI_W-1:gnc_pkg::MUL_LO_W]) *
                PH_W'(inv_len);
    end
  end

  // stage c: merge partial products, keep integer part, range check
  always_comb begin
    for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
      sum_c[a] = (gnc_pkg::PROD_W'(c_ph_r[a]) << gnc_pkg::MUL_LO_W) +
                 gnc_pkg::PROD_W'(c_pl_r[a]);
      q_c[a]   = sum_c[a][gnc_pkg::PROD_W-1:gnc_pkg::PROD_W-gnc_pkg::Q_W];
      in_c[a]  = !c_neg_r[a] && (q_c[a] < gnc_pkg::Q_W'(eff_cnt[a]));
    end
  end

  assign push = c_vld_r && (c_cls_r == gnc_pkg::CLS_PLUS);

  always_comb begin
    push_idx = asm_idx_r;
    push_in  = asm_in_r;
    for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
      push_idx[a][gnc_pkg::CLS_PLUS] = q_c[a][IW-1:0];
      push_in[a][gnc_pkg::CLS_PLUS]  = in_c[a];
    end
    push_flags.in_x = push_in[gnc_pkg::AXIS_X];
    push_flags.in_y = push_in[gnc_pkg::AXIS_Y];
    push_flags.in_z = push_in[gnc_pkg::AXIS_Z];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ph_r    <= gnc_pkg::CLS_MINUS;
      occ_r   <= '0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
      occ_r   <= occ_nxt;
      b_vld_r <= busy_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
        rel_r[a] <= gnc_pkg::REL_W'($signed(pos[a])) - gnc_pkg::REL_W'($signed(origin[a]));
      end
    end
    b_cls_r <= ph_r;
    b_off_r <= off_a;
    c_cls_r <= b_cls_r;
    c_pl_r  <= pl_b;
    c_ph_r  <= ph_b;
    for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
      c_neg_r[a] <= b_off_r[a][gnc_pkg::OFF_W-1];
    end
    if (c_vld_r) begin
      for (int a = 0; a < gnc_pkg::NUM_AXES; a++) begin
        asm_idx_r[a][c_cls_r] <= q_c[a][IW-1:0];
        asm_in_r[a][c_cls_r]  <= in_c[a];
      end
    end
  end

endmodule

/* src/gnc_fifo.sv */
// short queue between front and back end
module gnc_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          head_vld,
  output logic [DW-1:0] head_data
);

  localparam int PW = $clog2(gnc_pkg::FIFO_DEPTH);
  localparam int CNTW = $clog2(gnc_pkg::FIFO_DEPTH + 1);

  logic [DW-1:0]   mem_r [gnc_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign head_vld  = (cnt_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/gnc_back.sv */
// back end: walks the nine slots, linearizes, removes duplicates, holds the result
module gnc_back #(
  parameter int IW = 6,
  parameter int CW = 7,
  parameter int LW = 18
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    ent_avail,
  input  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0][IW-1:0] ent_idx,
  input  gnc_pkg::grid_flags_t                                    ent_flags,
  output logic                                                    ent_take,
  input  logic [CW-1:0]                                           nx,
  input  logic [2*CW-1:0]                                         nynx,
  output logic                                                    out_valid,
  input  logic                                                    out_stall,
  output logic [gnc_pkg::SLOT_W-1:0]                              out_slot,
  output logic signed [gnc_pkg::IDX_OUT_W-1:0]                    out_cell_index,
  output logic                                                    out_out_of_range,
  output logic                                                    out_last
);

  logic                                  ent_vld_r, ent_vld_nxt;
  logic [gnc_pkg::SLOT_W-1:0]            slot_r, slot_nxt;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0][IW-1:0] ent_idx_r;
  gnc_pkg::grid_flags_t                  ent_flags_r;

  logic                                  s1_vld_r;
  logic [gnc_pkg::SLOT_W-1:0]            s1_slot_r;
  logic [LW-1:0]                         s1_lin_r;
  logic                                  s1_in_r;

  logic                                  out_vld_r;
  logic [gnc_pkg::SLOT_W-1:0]            out_slot_r;
  logic [gnc_pkg::IDX_OUT_W-1:0]         out_idx_r;
  logic                                  out_oor_r;
  logic                                  out_last_r;

  logic [LW-1:0]                         seen_lin_r [gnc_pkg::NUM_SLOTS];
  logic [gnc_pkg::NUM_SLOTS-1:0]         seen_ok_r;

  logic                                  adv;
  logic [2:0]                            probe;
  gnc_pkg::cls_t                         cx, cy, cz;
  logic [IW-1:0]                         ix, iy, iz;
  logic                                  in0;
  logic [LW-1:0]                         lin0;
  logic                                  dup;

  assign adv      = !out_vld_r || !out_stall;
  assign ent_take = ent_avail && (!ent_vld_r || (adv && (slot_r == gnc_pkg::LAST_SLOT)));

  // probe bits pick minus or plus per axis: x msb, z lsb
  always_comb begin
    probe = 3'(slot_r - gnc_pkg::SLOT_W'(1));
    if (slot_r == gnc_pkg::FIRST_SLOT) begin
      cx = gnc_pkg::CLS_CENTER;
      cy = gnc_pkg::CLS_CENTER;
      cz = gnc_pkg::CLS_CENTER;
    end else begin
      cx = probe[2] ? gnc_pkg::CLS_PLUS : gnc_pkg::CLS_MINUS;
      cy = probe[1] ? gnc_pkg::CLS_PLUS : gnc_pkg::CLS_MINUS;
      cz = probe[0] ? gnc_pkg::CLS_PLUS : gnc_pkg::CLS_MINUS;
    end
    ix   = ent_idx_r[gnc_pkg::AXIS_X][cx];
    iy   = ent_idx_r[gnc_pkg::AXIS_Y][cy];
    iz   = ent_idx_r[gnc_pkg::AXIS_Z][cz];
    in0  = ent_flags_r.in_x[cx] && ent_flags_r.in_y[cy] && ent_flags_r.in_z[cz];
    lin0 = LW'(LW'(iz) * LW'(nynx)) + LW'(LW'(iy) * LW'(nx)) + LW'(ix);
  end

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < gnc_pkg::NUM_SLOTS; j++) begin
      if ((gnc_pkg::SLOT_W'(j) < s1_slot_r) && seen_ok_r[j] && (seen_lin_r[j] == s1_lin_r)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    slot_nxt    = slot_r;
    if (adv && ent_vld_r) begin
      if (slot_r == gnc_pkg::LAST_SLOT) begin
        ent_vld_nxt = 1'b0;
        slot_nxt    = gnc_pkg::FIRST_SLOT;
      end else begin
        slot_nxt = slot_r + gnc_pkg::SLOT_W'(1);
      end
    end
    if (ent_take) begin
      ent_vld_nxt = 1'b1;
      slot_nxt    = gnc_pkg::FIRST_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      slot_r    <= gnc_pkg::FIRST_SLOT;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
      slot_r    <= slot_nxt;
      if (adv) begin
        s1_vld_r  <= ent_vld_r;
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_take) begin
      ent_idx_r   <= ent_idx;
      ent_flags_r <= ent_flags;
    end
    if (adv) begin
      s1_slot_r  <= slot_r;
      s1_lin_r   <= lin0;
      s1_in_r    <= in0;
      out_slot_r <= s1_slot_r;
      out_idx_r  <= (s1_in_r && !dup) ? gnc_pkg::IDX_OUT_W'(s1_lin_r) : '1;
      out_oor_r  <= !s1_in_r;
      out_last_r <= (s1_slot_r == gnc_pkg::LAST_SLOT);
      if (s1_vld_r) begin
        seen_lin_r[s1_slot_r] <= s1_lin_r;
        seen_ok_r[s1_slot_r]  <= s1_in_r;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_slot         = out_slot_r;
  assign out_cell_index   = out_idx_r;
  assign out_out_of_range = out_oor_r;
  assign out_last         = out_last_r;

endmodule

/* src/grid_neighbor_cell_finder_core.sv */
// top level of the grid neighbor cell finder
//
// usage: a position (pos_x, pos_y, pos_z, signed q16.16) is one input transaction on
// in_valid / in_stall. for each position nine result transactions leave on out_valid /
// out_stall: slot 0 is the own cell, slots 1..8 the cells at plus or minus half a cell
// on every axis (x sign in the msb of slot-1, z sign in the lsb). a cell index of -1
// marks a probe outside the grid (out_of_range set) or a repeat of an earlier slot.
// out_last flags slot 8.
// the single result channel sets the pace; the front end handles one shift class per
// cycle through three multipliers split into two partial products each, and runs ahead
// through a 4-entry queue.
// configuration: cfg_index / cfg_data written on cfg_valid (cfg_ready is always high);
// the user writes only while no position is in flight; the block does not check it.
// reset (rst_n low, synchronous) empties all pipelines and the queue and restores the
// register defaults: origin 0, cell length and reciprocal 1.0, 16 cells per axis.
// a stalled receiver freezes the back end; the front end keeps taking positions until
// the queue is full, then raises in_stall.
module grid_neighbor_cell_finder_core #(
  parameter int MAX_AXIS_CELLS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gnc_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [gnc_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [gnc_pkg::POS_W-1:0]      in_pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [gnc_pkg::SLOT_W-1:0]            out_slot,
  output logic signed [gnc_pkg::IDX_OUT_W-1:0]  out_cell_index,
  output logic                                  out_out_of_range,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gnc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gnc_pkg::CFG_DAT_W-1:0]         cfg_data
);

  // axis index width, saturated count width, linear index width
  localparam int IW = $clog2(MAX_AXIS_CELLS);
  localparam int CW = $clog2(MAX_AXIS_CELLS + 1);
  localparam int LW = 3 * IW;
  localparam int FLAG_W = $bits(gnc_pkg::grid_flags_t);
  localparam int IDXS_W = gnc_pkg::NUM_AXES * gnc_pkg::NUM_CLS * IW;
  localparam int DW = FLAG_W + IDXS_W;

  // configuration registers
  logic [gnc_pkg::POS_W-1:0]     origin_x_r, origin_y_r, origin_z_r;
  logic [gnc_pkg::LEN_W-1:0]     cell_len_r, inv_len_r;
  logic [gnc_pkg::CNT_REG_W-1:0] cells_x_r, cells_y_r, cells_z_r;

  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::POS_W-1:0] pos, origin;
  logic [gnc_pkg::NUM_AXES-1:0][CW-1:0]             eff_cnt;
  logic [2*CW-1:0]                                  nynx_r;

  // front to queue, queue to back
  logic                                                    push, pop, head_vld;
  logic [gnc_pkg::NUM_AXES-1:0][gnc_pkg::NUM_CLS-1:0][IW-1:0] push_idx, head_idx;
  gnc_pkg::grid_flags_t                                    push_flags, head_flags;
  logic [DW-1:0]                                           push_data, head_data;

  function automatic logic [CW-1:0] sat_cnt(logic [gnc_pkg::CNT_REG_W-1:0] n);
    return (32'(n) > 32'(MAX_AXIS_CELLS)) ? CW'(MAX_AXIS_CELLS) : CW'(n);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      cell_len_r <= gnc_pkg::LEN_W'(65536);
      inv_len_r  <= gnc_pkg::LEN_W'(65536);
      cells_x_r  <= gnc_pkg::CNT_REG_W'(16);
      cells_y_r  <= gnc_pkg::CNT_REG_W'(16);
      cells_z_r  <= gnc_pkg::CNT_REG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (gnc_pkg::reg_idx_t'(cfg_index))
        gnc_pkg::REG_ORIGIN_X: origin_x_r <= cfg_data;
        gnc_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_data;
        gnc_pkg::REG_ORIGIN_Z: origin_z_r <= cfg_data;
        gnc_pkg::REG_CELL_LEN: cell_len_r <= cfg_data[gnc_pkg::LEN_W-1:0];
        gnc_pkg::REG_INV_LEN:  inv_len_r  <= cfg_data[gnc_pkg::LEN_W-1:0];
        gnc_pkg::REG_CELLS_X:  cells_x_r  <= cfg_data[gnc_pkg::CNT_REG_W-1:0];
        gnc_pkg::REG_CELLS_Y:  cells_y_r  <= cfg_data[gnc_pkg::CNT_REG_W-1:0];
        gnc_pkg::REG_CELLS_Z:  cells_z_r  <= cfg_data[gnc_pkg::CNT_REG_W-1:0];
      endcase
    end
  end

  // counts above the axis limit saturate to it
  assign eff_cnt[gnc_pkg::AXIS_X] = sat_cnt(cells_x_r);
  assign eff_cnt[gnc_pkg::AXIS_Y] = sat_cnt(cells_y_r);
  assign eff_cnt[gnc_pkg::AXIS_Z] = sat_cnt(cells_z_r);

  // plane size, clocked; user, not block, keeps config static while work is in flight
  always_ff @(posedge clk) begin
    nynx_r <= (2*CW)'(eff_cnt[gnc_pkg::AXIS_Y]) * (2*CW)'(eff_cnt[gnc_pkg::AXIS_X]);
  end

  assign pos[gnc_pkg::AXIS_X]    = in_pos_x;
  assign pos[gnc_pkg::AXIS_Y]    = in_pos_y;
  assign pos[gnc_pkg::AXIS_Z]    = in_pos_z;
  assign origin[gnc_pkg::AXIS_X] = origin_x_r;
  assign origin[gnc_pkg::AXIS_Y] = origin_y_r;
  assign origin[gnc_pkg::AXIS_Z] = origin_z_r;

  gnc_front #(
    .IW (IW),
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos        (pos),
    .origin     (origin),
    .half_len   (cell_len_r[gnc_pkg::LEN_W-1:1]),
    .inv_len    (inv_len_r),
    .eff_cnt    (eff_cnt),
    .pop        (pop),
    .push       (push),
    .push_idx   (push_idx),
    .push_flags (push_flags)
  );

  assign push_data  = {push_flags, push_idx};
  assign head_flags = head_data[DW-1:IDXS_W];
  assign head_idx   = head_data[IDXS_W-1:0];

  gnc_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_vld  (head_vld),
    .head_data (head_data)
  );

  gnc_back #(
    .IW (IW),
    .CW (CW),
    .LW (LW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ent_avail        (head_vld),
    .ent_idx          (head_idx),
    .ent_flags        (head_flags),
    .ent_take         (pop),
    .nx               (eff_cnt[gnc_pkg::AXIS_X]),
    .nynx             (nynx_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_cell_index   (out_cell_index),
    .out_out_of_range (out_out_of_range),
    .out_last         (out_last)
  );

endmodule

/* src/gnc_checker.sv */
// port-level checks of the grid neighbor cell finder, bound to the top level
module gnc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [gnc_pkg::SLOT_W-1:0]           out_slot,
  input logic signed [gnc_pkg::IDX_OUT_W-1:0] out_cell_index,
  input logic                                 out_out_of_range,
  input logic                                 out_last
);

  // last flag marks exactly the final slot
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_slot == gnc_pkg::LAST_SLOT)))
    else $error("last flag and slot disagree");

  // slots of one position leave back to back and in order
  a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && (out_slot == $past(out_slot) + gnc_pkg::SLOT_W'(1))))
    else $error("slot sequence broken");

  // an off-grid probe always reports the marker index
  a_oor_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_cell_index == '1))
    else $error("off-grid probe without marker index");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_neighbor_cell_finder_core gnc_checker u_gnc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_slot         (out_slot),
  .out_cell_index   (out_cell_index),
  .out_out_of_range (out_out_of_range),
  .out_last         (out_last)
);
